[hdl/qpn_pkg.sv]
package qpn_pkg;

    localparam int unsigned DATA_W        = 32;
    localparam int unsigned FRAC_BITS_DEF = 28;
    localparam int unsigned LANES         = 4;
    // the largest scaled magnitude sits in [2^29, 2^30) unless all are zero
    localparam int unsigned SCALE_MSB     = 29;
    localparam int unsigned SMAG_W        = 30;
    localparam int unsigned SQ_W          = 2 * SMAG_W;
    localparam int unsigned RAD_W         = 2 * SMAG_W + 2;
    localparam int unsigned ROOT_W        = RAD_W / 2;
    localparam int unsigned REM_W         = ROOT_W + 3;
    localparam int unsigned SH_W          = 5;
    localparam int unsigned POS_W         = 6;

    // term tables of the product: left index, right index, subtract flag
    localparam int unsigned LIDX [LANES][LANES] = '{
        '{0, 1, 2, 3}, '{0, 1, 2, 3}, '{0, 2, 3, 1}, '{0, 3, 1, 2}};
    localparam int unsigned RIDX [LANES][LANES] = '{
        '{0, 1, 2, 3}, '{1, 0, 3, 2}, '{2, 0, 1, 3}, '{3, 0, 2, 1}};
    localparam bit TNEG [LANES][LANES] = '{
        '{1'b0, 1'b1, 1'b1, 1'b1}, '{1'b0, 1'b0, 1'b0, 1'b1},
        '{1'b0, 1'b0, 1'b0, 1'b1}, '{1'b0, 1'b0, 1'b0, 1'b1}};

    typedef struct packed {
        logic              zero;
        logic [DATA_W-1:0] z;
        logic [DATA_W-1:0] y;
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] w;
    } qpn_result_t;

endpackage

[hdl/quaternion_product_normalized.sv]
// normalized hamilton product of two quaternions, one request per cycle
// input channel s_axis: tdata carries left w,x,y,z then right w,x,y,z,
// 32 bits each, signed, FRAC_BITS fraction bits
// output channel m_axis: tdata carries the unit product w,x,y,z, 32 bits
// each; tuser[0] is set when the product is zero, the data is then zero
// an accepted request passes through 8 front stages (products, sums,
// magnitude, max, shift search, shift, squares, sum of squares), one
// square root stage per root bit (31), one divider stage per quotient
// bit (FRAC_BITS + 1), then a two-entry output buffer before it shows
// on m_axis
// throughput: one request per cycle; every stage moves on a common
// enable that stays high while the output buffer has a free entry
// when the receiver stalls, the buffer fills, then the whole pipeline
// holds and s_axis_tready falls; nothing is dropped or repeated
// reset clears all valid bits and the buffer; data registers keep
// whatever they hold
module quaternion_product_normalized
    import qpn_pkg::*;
#(
    parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // left_w, left_x, left_y, left_z, right_w, right_x, right_y, right_z
    input  logic [255:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // prod_w, prod_x, prod_y, prod_z
    output logic [127:0]  m_axis_tdata,
    // zero_norm
    output logic [0:0]    m_axis_tuser
);

    localparam int unsigned PW = 66 - FRAC_BITS;
    localparam int unsigned MW = PW - 1;
    localparam int unsigned QB = FRAC_BITS + 1;
    localparam int unsigned DW = 32 + FRAC_BITS;
    localparam int unsigned NPROD = LANES * LANES;

    logic adv;

    // stage 1: products
    logic                     s1_valid_reg;
    logic signed [63:0]       prod_reg  [NPROD];
    logic signed [63:0]       prod_next [NPROD];
    // stage 2: sums
    logic                     s2_valid_reg;
    logic signed [PW-1:0]     sum_reg  [LANES];
    logic signed [PW-1:0]     sum_next [LANES];
    // stage 3: magnitude and sign
    logic                     s3_valid_reg;
    logic [MW-1:0]            mag3_reg  [LANES];
    logic [MW-1:0]            mag3_next [LANES];
    logic [LANES-1:0]         neg3_reg, neg3_next;
    // stage 4: largest magnitude
    logic                     s4_valid_reg;
    logic [MW-1:0]            mag4_reg [LANES];
    logic [LANES-1:0]         neg4_reg;
    logic [MW-1:0]            max4_reg, max4_next;
    // stage 5: shift search
    logic                     s5_valid_reg;
    logic [MW-1:0]            mag5_reg [LANES];
    logic [LANES-1:0]         neg5_reg;
    logic                     zero5_reg, zero5_next;
    logic                     right5_reg, right5_next;
    logic [SH_W-1:0]          sh5_reg, sh5_next;
    // stage 6: scaled magnitudes
    logic                     s6_valid_reg;
    logic [SMAG_W-1:0]        mag6_reg  [LANES];
    logic [SMAG_W-1:0]        mag6_next [LANES];
    logic [LANES-1:0]         neg6_reg;
    logic                     zero6_reg;
    // stage 7: squares
    logic                     s7_valid_reg;
    logic [SMAG_W-1:0]        mag7_reg [LANES];
    logic [LANES-1:0]         neg7_reg;
    logic                     zero7_reg;
    logic [SQ_W-1:0]          sq7_reg [LANES];
    // stage 8: sum of squares
    logic                     s8_valid_reg;
    logic [SMAG_W-1:0]        mag8_reg [LANES];
    logic [LANES-1:0]         neg8_reg;
    logic                     zero8_reg;
    logic [RAD_W-1:0]         ssum8_reg, ssum8_next;

    // square root, one root bit per stage
    logic                     rt_valid_reg [ROOT_W];
    logic [RAD_W-1:0]         rt_rad_reg   [ROOT_W];
    logic [RAD_W-1:0]         rt_rad_next  [ROOT_W];
    logic [REM_W-1:0]         rt_rem_reg   [ROOT_W];
    logic [REM_W-1:0]         rt_rem_next  [ROOT_W];
    logic [ROOT_W-1:0]        rt_root_reg  [ROOT_W];
    logic [ROOT_W-1:0]        rt_root_next [ROOT_W];
    logic [SMAG_W-1:0]        rt_mag_reg   [ROOT_W][LANES];
    logic [LANES-1:0]         rt_neg_reg   [ROOT_W];
    logic                     rt_zero_reg  [ROOT_W];

    // divider, one quotient bit per stage, four lanes
    logic                     dv_valid_reg [QB];
    logic [ROOT_W-1:0]        dv_n_reg     [QB];
    logic [DW-1:0]            dv_rem_reg   [QB][LANES];
    logic [DW-1:0]            dv_rem_next  [QB][LANES];
    logic [QB-1:0]            dv_q_reg     [QB][LANES];
    logic [QB-1:0]            dv_q_next    [QB][LANES];
    logic [LANES-1:0]         dv_neg_reg   [QB];
    logic                     dv_zero_reg  [QB];

    // output buffer
    qpn_result_t              res;
    qpn_result_t              head_reg, head_next, tail_reg, tail_next;
    logic                     head_valid_reg, head_valid_next;
    logic                     tail_valid_reg, tail_valid_next;
    logic                     push, pop;

    assign adv           = !tail_valid_reg;
    assign s_axis_tready = adv;

    // stage 1
    always_comb
    begin
        logic signed [DATA_W-1:0] lw [LANES];
        logic signed [DATA_W-1:0] rw [LANES];
        for (int i = 0; i < LANES; i++)
        begin
            lw[i] = s_axis_tdata[i*DATA_W +: DATA_W];
            rw[i] = s_axis_tdata[(i+LANES)*DATA_W +: DATA_W];
        end
        for (int j = 0; j < LANES; j++)
        begin
            for (int t = 0; t < LANES; t++)
            begin
                prod_next[j*LANES+t] = lw[LIDX[j][t]] * rw[RIDX[j][t]];
            end
        end
    end

    // stage 2: floor shift of every product, then the signed sum
    always_comb
    begin
        logic signed [PW-1:0] acc;
        logic signed [PW-1:0] term;
        for (int j = 0; j < LANES; j++)
        begin
            acc = '0;
            for (int t = 0; t < LANES; t++)
            begin
                term = PW'(prod_reg[j*LANES+t] >>> FRAC_BITS);
                acc  = TNEG[j][t] ? acc - term : acc + term;
            end
            sum_next[j] = acc;
        end
    end

    // stage 3
    always_comb
    begin
        for (int j = 0; j < LANES; j++)
        begin
            neg3_next[j] = sum_reg[j][PW-1];
            mag3_next[j] = neg3_next[j] ? MW'(-sum_reg[j]) : MW'(sum_reg[j]);
        end
    end

    // stage 4
    always_comb
    begin
        logic [MW-1:0] m01;
        logic [MW-1:0] m23;
        m01       = (mag3_reg[0] > mag3_reg[1]) ? mag3_reg[0] : mag3_reg[1];
        m23       = (mag3_reg[2] > mag3_reg[3]) ? mag3_reg[2] : mag3_reg[3];
        max4_next = (m01 > m23) ? m01 : m23;
    end

    // stage 5: position of the leading one picks the common shift
    always_comb
    begin
        logic [POS_W-1:0] msb;
        msb = '0;
        for (int i = 0; i < MW; i++)
        begin
            if (max4_reg[i])
            begin
                msb = POS_W'(i);
            end
        end
        zero5_next  = (max4_reg == '0);
        right5_next = (msb > POS_W'(SCALE_MSB));
        if (right5_next)
        begin
            sh5_next = SH_W'(msb - POS_W'(SCALE_MSB));
        end
        else
        begin
            sh5_next = SH_W'(POS_W'(SCALE_MSB) - msb);
        end
    end

    // stage 6
    always_comb
    begin
        logic [MW-1:0] sv;
        for (int j = 0; j < LANES; j++)
        begin
            sv = right5_reg ? (mag5_reg[j] >> sh5_reg) : (mag5_reg[j] << sh5_reg);
            mag6_next[j] = sv[SMAG_W-1:0];
        end
    end

    // stage 8
    assign ssum8_next = RAD_W'(sq7_reg[0]) + RAD_W'(sq7_reg[1])
                      + RAD_W'(sq7_reg[2]) + RAD_W'(sq7_reg[3]);

    // square root steps
    always_comb
    begin
        logic [RAD_W-1:0]  rad_in;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [REM_W-1:0]  rem2;
        logic [REM_W-1:0]  trial;
        for (int k = 0; k < ROOT_W; k++)
        begin
            if (k == 0)
            begin
                rad_in  = ssum8_reg;
                rem_in  = '0;
                root_in = '0;
            end
            else
            begin
                rad_in  = rt_rad_reg[k-1];
                rem_in  = rt_rem_reg[k-1];
                root_in = rt_root_reg[k-1];
            end
            rem2  = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
            trial = REM_W'({root_in, 2'b01});
            rt_rad_next[k] = rad_in << 2;
            if (rem2 >= trial)
            begin
                rt_rem_next[k]  = rem2 - trial;
                rt_root_next[k] = {root_in[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rt_rem_next[k]  = rem2;
                rt_root_next[k] = {root_in[ROOT_W-2:0], 1'b0};
            end
        end
    end

    // divider steps: rounded numerator, then restoring subtract per bit
    always_comb
    begin
        logic [ROOT_W-1:0] n_in;
        logic [DW-1:0]     rem_in;
        logic [QB-1:0]     q_in;
        logic [DW-1:0]     dsh;
        logic              ge;
        for (int t = 0; t < QB; t++)
        begin
            for (int j = 0; j < LANES; j++)
            begin
                if (t == 0)
                begin
                    n_in   = rt_root_reg[ROOT_W-1];
                    rem_in = (DW'(rt_mag_reg[ROOT_W-1][j]) << FRAC_BITS)
                           + DW'(n_in >> 1);
                    q_in   = '0;
                end
                else
                begin
                    n_in   = dv_n_reg[t-1];
                    rem_in = dv_rem_reg[t-1][j];
                    q_in   = dv_q_reg[t-1][j];
                end
                dsh = DW'(n_in) << (QB - 1 - t);
                ge  = (rem_in >= dsh);
                dv_rem_next[t][j] = ge ? rem_in - dsh : rem_in;
                dv_q_next[t][j]   = {q_in[QB-2:0], ge};
            end
        end
    end

    always_comb
    begin
        logic [DATA_W-1:0] qv [LANES];
        logic [DATA_W-1:0] rv [LANES];
        for (int j = 0; j < LANES; j++)
        begin
            qv[j] = DATA_W'(dv_q_reg[QB-1][j]);
            rv[j] = dv_neg_reg[QB-1][j] ? -qv[j] : qv[j];
            if (dv_zero_reg[QB-1])
            begin
                rv[j] = '0;
            end
        end
        res.w    = rv[0];
        res.x    = rv[1];
        res.y    = rv[2];
        res.z    = rv[3];
        res.zero = dv_zero_reg[QB-1];
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
            s8_valid_reg <= 1'b0;
            for (int k = 0; k < ROOT_W; k++)
            begin
                rt_valid_reg[k] <= 1'b0;
            end
            for (int t = 0; t < QB; t++)
            begin
                dv_valid_reg[t] <= 1'b0;
            end
        end
        else if (adv)
        begin
            s1_valid_reg <= s_axis_tvalid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
            s7_valid_reg <= s6_valid_reg;
            s8_valid_reg <= s7_valid_reg;
            rt_valid_reg[0] <= s8_valid_reg;
            for (int k = 1; k < ROOT_W; k++)
            begin
                rt_valid_reg[k] <= rt_valid_reg[k-1];
            end
            dv_valid_reg[0] <= rt_valid_reg[ROOT_W-1];
            for (int t = 1; t < QB; t++)
            begin
                dv_valid_reg[t] <= dv_valid_reg[t-1];
            end
        end
    end

    // pipeline data
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg  <= prod_next;
            sum_reg   <= sum_next;
            mag3_reg  <= mag3_next;
            neg3_reg  <= neg3_next;
            mag4_reg  <= mag3_reg;
            neg4_reg  <= neg3_reg;
            max4_reg  <= max4_next;
            mag5_reg  <= mag4_reg;
            neg5_reg  <= neg4_reg;
            zero5_reg <= zero5_next;
            right5_reg <= right5_next;
            sh5_reg   <= sh5_next;
            mag6_reg  <= mag6_next;
            neg6_reg  <= neg5_reg;
            zero6_reg <= zero5_reg;
            mag7_reg  <= mag6_reg;
            neg7_reg  <= neg6_reg;
            zero7_reg <= zero6_reg;
            for (int j = 0; j < LANES; j++)
            begin
                sq7_reg[j] <= mag6_reg[j] * mag6_reg[j];
            end
            mag8_reg  <= mag7_reg;
            neg8_reg  <= neg7_reg;
            zero8_reg <= zero7_reg;
            ssum8_reg <= ssum8_next;

            rt_rad_reg  <= rt_rad_next;
            rt_rem_reg  <= rt_rem_next;
            rt_root_reg <= rt_root_next;
            rt_mag_reg[0]  <= mag8_reg;
            rt_neg_reg[0]  <= neg8_reg;
            rt_zero_reg[0] <= zero8_reg;
            for (int k = 1; k < ROOT_W; k++)
            begin
                rt_mag_reg[k]  <= rt_mag_reg[k-1];
                rt_neg_reg[k]  <= rt_neg_reg[k-1];
                rt_zero_reg[k] <= rt_zero_reg[k-1];
            end

            dv_rem_reg <= dv_rem_next;
            dv_q_reg   <= dv_q_next;
            dv_n_reg[0]    <= rt_root_reg[ROOT_W-1];
            dv_neg_reg[0]  <= rt_neg_reg[ROOT_W-1];
            dv_zero_reg[0] <= rt_zero_reg[ROOT_W-1];
            for (int t = 1; t < QB; t++)
            begin
                dv_n_reg[t]    <= dv_n_reg[t-1];
                dv_neg_reg[t]  <= dv_neg_reg[t-1];
                dv_zero_reg[t] <= dv_zero_reg[t-1];
            end
        end
    end

    // two-entry output buffer
    assign push = adv && dv_valid_reg[QB-1];
    assign pop  = head_valid_reg && m_axis_tready;

    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        head_valid_next = head_valid_reg;
        tail_valid_next = tail_valid_reg;
        if (pop)
        begin
            if (tail_valid_reg)
            begin
                head_next       = tail_reg;
                tail_valid_next = 1'b0;
            end
            else
            begin
                head_valid_next = 1'b0;
            end
        end
        if (push)
        begin
            if (!head_valid_next)
            begin
                head_next       = res;
                head_valid_next = 1'b1;
            end
            else
            begin
                tail_next       = res;
                tail_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            tail_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            tail_valid_reg <= tail_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    assign m_axis_tvalid   = head_valid_reg;
    assign m_axis_tdata    = {head_reg.z, head_reg.y, head_reg.x, head_reg.w};
    assign m_axis_tuser[0] = head_reg.zero;

    a_tail_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        tail_valid_reg |-> head_valid_reg)
        else $error("buffer tail filled while head empty");

    a_zero_flag_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("zero norm result carries nonzero data");

    a_last_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        dv_valid_reg[QB-1] && !adv |=> dv_valid_reg[QB-1])
        else $error("result lost while pipeline held");

endmodule
